[sv/ncm_pkg.sv]
// ----------------------------------------------------------------------------
// ncm_pkg: shared types and constants of the normalisation cube map
// Widths of the direction vector, the search datapath and the face table.
// ----------------------------------------------------------------------------
package ncm_pkg;

    // Field widths of the transaction and of the configuration register.
    localparam int COORD_BITS = 10;
    localparam int FACE_BITS  = 3;
    localparam int SIZE_BITS  = 11;
    localparam int BYTE_BITS  = 8;

    // Fraction bits of a unit component, one bit resolved per search stage.
    localparam int FRAC_BITS = 16;

    // Datapath widths, derived from the coordinate, fraction and size widths.
    localparam int COMP_W  = COORD_BITS + 2;          // signed component
    localparam int MAG_W   = COORD_BITS + 1;          // component magnitude
    localparam int SQ_W    = 2 * MAG_W;               // squared magnitude
    localparam int LEN_W   = SQ_W + 2;                // sum of three squares
    localparam int TGT_W   = SQ_W + 2 * FRAC_BITS;    // scaled square / remainder
    localparam int LPROD_W = FRAC_BITS + LEN_W;       // partial quotient times length
    localparam int DIV_W   = TGT_W + 2;               // trial decrement
    localparam int UNIT_W  = FRAC_BITS + 1;           // magnitude up to exactly one
    localparam int N_W     = (SIZE_BITS > COORD_BITS + 1) ? SIZE_BITS : COORD_BITS + 1;

    // Face size limits and reset value.
    localparam int SIZE_MIN   = 2;
    localparam int SIZE_MAX   = 1 << COORD_BITS;
    localparam int SIZE_RESET = 256;

    localparam logic [UNIT_W-1:0] UNIT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [FACE_BITS-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [2:0] comp_vec_t;

    // One component's state within the reciprocal square root search.
    typedef struct packed {
        logic                neg;
        logic                zero;
        logic                full;
        logic [TGT_W-1:0]    rem;
        logic [LPROD_W-1:0]  lprod;
        logic [FRAC_BITS-1:0] quo;
    } lane_t;

    // One texel in flight through the search pipeline.
    typedef struct packed {
        logic [LEN_W-1:0] len2;
        lane_t [2:0]      lane;
    } job_t;

    // Signed unit magnitudes leaving the search pipeline.
    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][UNIT_W-1:0]  mag;
    } unit_res_t;

    // Direction to the texel on a grid from -m to m, scaled by m = n - 1.
    // Lane 0 is x, lane 1 is y and lane 2 is z.
    function automatic comp_vec_t face_vector(input logic [FACE_BITS-1:0] face,
                                              input comp_t axis_m,
                                              input comp_t a,
                                              input comp_t b);
        comp_vec_t v;
        v = '0;
        unique case (face)
            FACE_POS_X: begin
                v[0] = axis_m;  v[1] = -b;      v[2] = -a;
            end
            FACE_NEG_X: begin
                v[0] = -axis_m; v[1] = -b;      v[2] = a;
            end
            FACE_POS_Y: begin
                v[0] = a;       v[1] = axis_m;  v[2] = b;
            end
            FACE_NEG_Y: begin
                v[0] = a;       v[1] = -axis_m; v[2] = -b;
            end
            FACE_POS_Z: begin
                v[0] = a;       v[1] = -b;      v[2] = axis_m;
            end
            FACE_NEG_Z: begin
                v[0] = -a;      v[1] = -b;      v[2] = -axis_m;
            end
            default: begin
                // Unused face codes give the zero vector.
                v = '0;
            end
        endcase
        return v;
    endfunction

endpackage

[sv/ncm_rsqrt_pipe.sv]
// ----------------------------------------------------------------------------
// ncm_rsqrt_pipe: pipelined unit-vector magnitude search
// Resolves floor(|c| * 2^16 / sqrt(len2)) one quotient bit per stage for all
// three components, using only shifts, adds and compares.
// ----------------------------------------------------------------------------
module ncm_rsqrt_pipe (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ncm_pkg::job_t      in_job,
    output logic               out_valid,
    input  logic               out_ready,
    output ncm_pkg::unit_res_t out_res
);
    import ncm_pkg::*;

    localparam int STEPS = FRAC_BITS;

    // One restoring step: try setting the quotient bit and keep it when
    // (q + 2^b)^2 * len2 still fits under the scaled square. The remainder
    // holds target - q^2 * len2 and lprod holds q * len2.
    function automatic job_t search_step(input job_t j, input int bit_pos);
        job_t             r;
        logic [DIV_W-1:0] dec;
        logic [DIV_W-1:0] len_w;
        r     = j;
        len_w = DIV_W'(j.len2);
        for (int k = 0; k < 3; k++) begin
            dec = (DIV_W'(j.lane[k].lprod) << (bit_pos + 1)) + (len_w << (2 * bit_pos));
            if (dec <= DIV_W'(j.lane[k].rem)) begin
                r.lane[k].rem   = j.lane[k].rem - TGT_W'(dec);
                r.lane[k].lprod = j.lane[k].lprod + LPROD_W'(len_w << bit_pos);
                r.lane[k].quo   = j.lane[k].quo | (FRAC_BITS'(1) << bit_pos);
            end
        end
        return r;
    endfunction

    logic valid_reg  [STEPS];
    job_t job_reg    [STEPS];
    job_t job_next   [STEPS];
    logic prev_valid [STEPS];
    job_t prev_job   [STEPS];
    logic adv        [STEPS+1];

    logic [2:0] unit_zero;
    logic [2:0] unit_full;

    assign adv[STEPS] = out_ready;

    // Search stages, most significant quotient bit first.
    generate
        for (genvar i = 0; i < STEPS; i++) begin : g_step
            if (i == 0) begin : g_first
                assign prev_valid[i] = in_valid;
                assign prev_job[i]   = in_job;
            end else begin : g_rest
                assign prev_valid[i] = valid_reg[i-1];
                assign prev_job[i]   = job_reg[i-1];
            end

            assign job_next[i] = search_step(prev_job[i], STEPS - 1 - i);

            // A stage moves on when it is empty or the next one moves on.
            assign adv[i] = !valid_reg[i] || adv[i+1];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i] <= 1'b0;
                end else if (adv[i]) begin
                    valid_reg[i] <= prev_valid[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv[i]) begin
                    job_reg[i] <= job_next[i];
                end
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STEPS-1];

    // Zero components and components on the face axis bypass the search.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            unit_zero[k]   = job_reg[STEPS-1].lane[k].zero;
            unit_full[k]   = job_reg[STEPS-1].lane[k].full;
            out_res.neg[k] = job_reg[STEPS-1].lane[k].neg;
            if (unit_zero[k]) begin
                out_res.mag[k] = '0;
            end else if (unit_full[k]) begin
                out_res.mag[k] = UNIT_ONE;
            end else begin
                out_res.mag[k] = {1'b0, job_reg[STEPS-1].lane[k].quo};
            end
        end
    end

    // The finished search keeps lprod = q * len2 and leaves q maximal.
    generate
        for (genvar k = 0; k < 3; k++) begin : g_chk
            a_search_exact: assert property (@(posedge aclk) disable iff (!aresetn)
                (valid_reg[STEPS-1] && !unit_zero[k] && !unit_full[k]) |->
                ((job_reg[STEPS-1].lane[k].lprod ==
                  LPROD_W'(job_reg[STEPS-1].lane[k].quo) * LPROD_W'(job_reg[STEPS-1].len2))
                 && (DIV_W'(job_reg[STEPS-1].lane[k].rem) <
                     (DIV_W'(job_reg[STEPS-1].lane[k].lprod) << 1)
                     + DIV_W'(job_reg[STEPS-1].len2))))
                else $error("search stage left a wrong or non-maximal quotient");
        end
    endgenerate

    // An on-axis direction has both other components at zero.
    a_full_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && (unit_full != 3'b000)) |->
        ($onehot(unit_full) && ($countones(unit_zero) == 2)))
        else $error("on-axis component seen with a nonzero neighbour");

endmodule

[sv/normalization_cubemap_texel.sv]
// ----------------------------------------------------------------------------
// normalization_cubemap_texel: normalisation cube map texel generator
// Turns a (face, column, row) request into the RGB-encoded unit direction
// towards that texel.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (s_face, s_col, s_row) is taken on s_valid and
//   s_ready; the encoded direction leaves as one transaction on m_red,
//   m_green and m_blue under m_valid and m_ready.
//   The face size is written through cfg_wr_en / cfg_wr_data while no
//   transaction is in flight; values below 2 act as 2 and values above
//   1024 act as 1024.
//   Throughput is one texel per cycle while m_ready is high. There are
//   twenty register stages and the accepting edge loads the first: three
//   front stages (vector, squares, length), sixteen search stages that each
//   resolve one bit of the normalised magnitude, and the output register
//   holding the encoded bytes.
//   Reset clears every valid bit and sets the face size to 256.
//   When the receiver stalls, a stage holds only while the stage after it is
//   full, so bubbles close up and s_ready falls once every stage is occupied.
//   With m_ready high, s_ready is high.
// ----------------------------------------------------------------------------
module normalization_cubemap_texel (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ncm_pkg::SIZE_BITS-1:0]    cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ncm_pkg::FACE_BITS-1:0]    s_face,
    input  logic [ncm_pkg::COORD_BITS-1:0]   s_col,
    input  logic [ncm_pkg::COORD_BITS-1:0]   s_row,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ncm_pkg::BYTE_BITS-1:0]    m_red,
    output logic [ncm_pkg::BYTE_BITS-1:0]    m_green,
    output logic [ncm_pkg::BYTE_BITS-1:0]    m_blue
);
    import ncm_pkg::*;

    // byte = floor(255 * (2^16 + c) / 2^17) for signed unit value c.
    function automatic logic [BYTE_BITS-1:0] encode(input logic neg,
                                                   input logic [UNIT_W-1:0] mag);
        logic [FRAC_BITS+1:0]           biased;
        logic [FRAC_BITS+BYTE_BITS+1:0] scaled;
        biased = neg ? ((FRAC_BITS+2)'(UNIT_ONE) - (FRAC_BITS+2)'(mag))
                     : ((FRAC_BITS+2)'(UNIT_ONE) + (FRAC_BITS+2)'(mag));
        scaled = {biased, BYTE_BITS'(0)} - (FRAC_BITS+BYTE_BITS+2)'(biased);
        return scaled[FRAC_BITS+BYTE_BITS:FRAC_BITS+1];
    endfunction

    logic [SIZE_BITS-1:0] face_size_reg;

    logic      a_valid_reg, a_adv;
    comp_vec_t a_comp_reg, a_comp_next;

    logic                   b_valid_reg, b_adv;
    logic [2:0]             b_neg_reg, b_neg_next;
    logic [2:0][SQ_W-1:0]   b_sq_reg, b_sq_next;

    logic c_valid_reg, c_adv;
    job_t c_job_reg, c_job_next;

    logic      unit_in_ready;
    logic      unit_valid;
    unit_res_t unit_res;

    logic                 m_valid_reg, out_adv;
    logic [BYTE_BITS-1:0] m_red_reg, m_green_reg, m_blue_reg;
    logic [BYTE_BITS-1:0] m_red_next, m_green_next, m_blue_next;

    logic [N_W-1:0]        n_clamped;
    logic [COORD_BITS-1:0] m_val;
    comp_t                 m_comp, a_val, b_val;
    logic [MAG_W-1:0]      ax;
    logic [LEN_W-1:0]      len2;

    // Face size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_size_reg <= SIZE_BITS'(SIZE_RESET);
        end else if (cfg_wr_en) begin
            face_size_reg <= cfg_wr_data;
        end
    end

    // Backpressure chain, output side first.
    assign out_adv = !m_valid_reg || m_ready;
    assign c_adv   = !c_valid_reg || unit_in_ready;
    assign b_adv   = !b_valid_reg || c_adv;
    assign a_adv   = !a_valid_reg || b_adv;
    assign s_ready = a_adv;

    // Stage A: clamp the face size and form the scaled direction.
    always_comb begin
        priority if (face_size_reg < SIZE_BITS'(SIZE_MIN)) begin
            n_clamped = N_W'(SIZE_MIN);
        end else if (N_W'(face_size_reg) > N_W'(SIZE_MAX)) begin
            n_clamped = N_W'(SIZE_MAX);
        end else begin
            n_clamped = N_W'(face_size_reg);
        end
        m_val       = COORD_BITS'(n_clamped - N_W'(1));
        m_comp      = comp_t'({2'b00, m_val});
        a_val       = comp_t'({1'b0, s_col, 1'b0}) - m_comp;
        b_val       = comp_t'({1'b0, s_row, 1'b0}) - m_comp;
        a_comp_next = face_vector(s_face, m_comp, a_val, b_val);
    end

    // Stage B: magnitudes and squares.
    always_comb begin
        ax = '0;
        for (int k = 0; k < 3; k++) begin
            b_neg_next[k] = a_comp_reg[k][COMP_W-1];
            ax            = MAG_W'(b_neg_next[k] ? -a_comp_reg[k] : a_comp_reg[k]);
            b_sq_next[k]  = SQ_W'(ax * ax);
        end
    end

    // Stage C: squared length and the initial search state.
    always_comb begin
        len2 = LEN_W'(b_sq_reg[0]) + LEN_W'(b_sq_reg[1]) + LEN_W'(b_sq_reg[2]);
        c_job_next.len2 = len2;
        for (int k = 0; k < 3; k++) begin
            c_job_next.lane[k].neg   = b_neg_reg[k];
            c_job_next.lane[k].zero  = (b_sq_reg[k] == '0);
            c_job_next.lane[k].full  = (len2 == LEN_W'(b_sq_reg[k])) && (b_sq_reg[k] != '0);
            c_job_next.lane[k].rem   = {b_sq_reg[k], (2*FRAC_BITS)'(0)};
            c_job_next.lane[k].lprod = '0;
            c_job_next.lane[k].quo   = '0;
        end
    end

    // Valid bits of the front stages and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_adv) begin
                a_valid_reg <= s_valid;
            end
            if (b_adv) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_adv) begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_adv) begin
                m_valid_reg <= unit_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_adv) begin
            a_comp_reg <= a_comp_next;
        end
        if (b_adv) begin
            b_neg_reg <= b_neg_next;
            b_sq_reg  <= b_sq_next;
        end
        if (c_adv) begin
            c_job_reg <= c_job_next;
        end
        if (out_adv) begin
            m_red_reg   <= m_red_next;
            m_green_reg <= m_green_next;
            m_blue_reg  <= m_blue_next;
        end
    end

    ncm_rsqrt_pipe u_rsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid_reg),
        .in_ready  (unit_in_ready),
        .in_job    (c_job_reg),
        .out_valid (unit_valid),
        .out_ready (out_adv),
        .out_res   (unit_res)
    );

    // Byte encoding into the output register.
    always_comb begin
        m_red_next   = encode(unit_res.neg[0], unit_res.mag[0]);
        m_green_next = encode(unit_res.neg[1], unit_res.mag[1]);
        m_blue_next  = encode(unit_res.neg[2], unit_res.mag[2]);
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_red_reg;
    assign m_green = m_green_reg;
    assign m_blue  = m_blue_reg;

    // A ready receiver never stalls the request side.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("request side stalled while the receiver was ready");

    // At most one component can lie on the face axis.
    a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> $onehot0({c_job_reg.lane[2].full, c_job_reg.lane[1].full,
                                  c_job_reg.lane[0].full}))
        else $error("more than one component marked as on-axis");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result transaction offered right after reset");

endmodule
